@@ hw/rtl/tfn_pkg.sv @@
package tfn_pkg;

  // Normalised magnitude width before the length calculation
  localparam int Q_BITS = 30;
  // Sum of three squares of Q_BITS values, and the root that it gives
  localparam int SUM_W  = 2 * Q_BITS + 2;
  localparam int ROOT_W = Q_BITS + 1;

  // Control travelling alongside each item
  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } tfn_ctl_t;

endpackage

@@ hw/rtl/triangle_face_normal.sv @@
// Channel  | Ports                               | Handshake
// ---------+-------------------------------------+------------------------------
// input    | in_vertex_{a,b,c}_{x,y,z}           | start, taken when busy low
// result   | out_normal_{x,y,z}, out_degenerate  | out_valid, one-cycle strobe
//
// One item accepted every cycle; busy never rises.
// Pipeline: seven front stages (edges, products, cross, length, shift, squares,
// sum), 31 square root cells, one prepare stage, NORMAL_FRAC_BITS + 1 divide
// cells and the output register.
// Reset clears the valid bits along the pipeline; data registers are not reset.
module triangle_face_normal import tfn_pkg::*; #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_WIDTH-1:0]        in_vertex_a_x,
  input  logic [COORD_WIDTH-1:0]        in_vertex_a_y,
  input  logic [COORD_WIDTH-1:0]        in_vertex_a_z,
  input  logic [COORD_WIDTH-1:0]        in_vertex_b_x,
  input  logic [COORD_WIDTH-1:0]        in_vertex_b_y,
  input  logic [COORD_WIDTH-1:0]        in_vertex_b_z,
  input  logic [COORD_WIDTH-1:0]        in_vertex_c_x,
  input  logic [COORD_WIDTH-1:0]        in_vertex_c_y,
  input  logic [COORD_WIDTH-1:0]        in_vertex_c_z,
  output logic                          out_valid,
  output logic [NORMAL_FRAC_BITS+1:0]   out_normal_x,
  output logic [NORMAL_FRAC_BITS+1:0]   out_normal_y,
  output logic [NORMAL_FRAC_BITS+1:0]   out_normal_z,
  output logic                          out_degenerate
);

  localparam int EW    = COORD_WIDTH + 1;
  localparam int PW    = 2 * EW;
  localparam int XW    = PW + 1;
  localparam int LW    = $clog2(XW + 1);
  localparam int F     = NORMAL_FRAC_BITS;
  localparam int OW    = F + 2;
  localparam int QW    = F + 1;
  localparam int NUM_W = Q_BITS + F + 2;
  localparam int DEN_W = ROOT_W + 1;
  localparam int LAT   = 7 + ROOT_W + 1 + QW + 1;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: edges from vertex A
  logic               v1_r;
  logic signed [EW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    e1x_r <= $signed({in_vertex_b_x[COORD_WIDTH-1], in_vertex_b_x})
           - $signed({in_vertex_a_x[COORD_WIDTH-1], in_vertex_a_x});
    e1y_r <= $signed({in_vertex_b_y[COORD_WIDTH-1], in_vertex_b_y})
           - $signed({in_vertex_a_y[COORD_WIDTH-1], in_vertex_a_y});
    e1z_r <= $signed({in_vertex_b_z[COORD_WIDTH-1], in_vertex_b_z})
           - $signed({in_vertex_a_z[COORD_WIDTH-1], in_vertex_a_z});
    e2x_r <= $signed({in_vertex_c_x[COORD_WIDTH-1], in_vertex_c_x})
           - $signed({in_vertex_a_x[COORD_WIDTH-1], in_vertex_a_x});
    e2y_r <= $signed({in_vertex_c_y[COORD_WIDTH-1], in_vertex_c_y})
           - $signed({in_vertex_a_y[COORD_WIDTH-1], in_vertex_a_y});
    e2z_r <= $signed({in_vertex_c_z[COORD_WIDTH-1], in_vertex_c_z})
           - $signed({in_vertex_a_z[COORD_WIDTH-1], in_vertex_a_z});
  end

  // Stage 2: six partial products of the cross product
  logic                 v2_r;
  logic signed [PW-1:0] p_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r[0] <= e1y_r * e2z_r;
    p_r[1] <= e1z_r * e2y_r;
    p_r[2] <= e1z_r * e2x_r;
    p_r[3] <= e1x_r * e2z_r;
    p_r[4] <= e1x_r * e2y_r;
    p_r[5] <= e1y_r * e2x_r;
  end

  // Stage 3: cross product, split into sign and magnitude
  logic                 v3_r;
  logic [2:0]           neg3_r;
  logic [2:0][XW-1:0]   mag3_r;
  logic signed [XW-1:0] cr [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cr[k] = XW'(p_r[2*k]) - XW'(p_r[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      neg3_r[k] <= cr[k][XW-1];
      mag3_r[k] <= cr[k][XW-1] ? XW'(-cr[k]) : XW'(cr[k]);
    end
  end

  // Stage 4: bit length of the largest magnitude
  logic               v4_r;
  logic [2:0]         neg4_r;
  logic [2:0][XW-1:0] mag4_r;
  logic [LW-1:0]      len4_r, len_nxt;
  logic [XW-1:0]      orv;

  always_comb begin
    orv     = mag3_r[0] | mag3_r[1] | mag3_r[2];
    len_nxt = '0;
    for (int b = 0; b < XW; b++) begin
      if (orv[b]) len_nxt = LW'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    neg4_r <= neg3_r;
    mag4_r <= mag3_r;
    len4_r <= len_nxt;
  end

  // Stage 5: scale so the largest magnitude is Q_BITS long
  tfn_ctl_t               c5_r;
  logic [2:0][Q_BITS-1:0] q5_r;
  logic [XW+Q_BITS-1:0]   wide [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wide[k] = {mag4_r[k], {Q_BITS{1'b0}}} >> len4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c5_r <= '0;
    end else begin
      c5_r.valid <= v4_r;
      c5_r.degen <= (len4_r == '0);
      c5_r.neg   <= neg4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      q5_r[k] <= wide[k][Q_BITS-1:0];
    end
  end

  // Stage 6: squares
  tfn_ctl_t                 c6_r;
  logic [2:0][Q_BITS-1:0]   q6_r;
  logic [2:0][2*Q_BITS-1:0] sq6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c6_r <= '0;
    end else begin
      c6_r <= c5_r;
    end
  end

  always_ff @(posedge clk) begin
    q6_r <= q5_r;
    for (int k = 0; k < 3; k++) begin
      sq6_r[k] <= q5_r[k] * q5_r[k];
    end
  end

  // Stage 7: sum of squares
  tfn_ctl_t               c7_r;
  logic [2:0][Q_BITS-1:0] q7_r;
  logic [SUM_W-1:0]       sum7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c7_r <= '0;
    end else begin
      c7_r <= c6_r;
    end
  end

  always_ff @(posedge clk) begin
    q7_r   <= q6_r;
    sum7_r <= SUM_W'(sq6_r[0]) + SUM_W'(sq6_r[1]) + SUM_W'(sq6_r[2]);
  end

  // Square root chain, one root bit per cell
  tfn_ctl_t               sc   [ROOT_W+1];
  logic [SUM_W-1:0]       srem [ROOT_W+1];
  logic [SUM_W-1:0]       sres [ROOT_W+1];
  logic [2:0][Q_BITS-1:0] sq   [ROOT_W+1];

  assign sc[0]   = c7_r;
  assign srem[0] = sum7_r;
  assign sres[0] = '0;
  assign sq[0]   = q7_r;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    tfn_sqrt_cell #(
      .BIT_IDX(ROOT_W - 1 - i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (sc[i]),
      .rem_i (srem[i]),
      .res_i (sres[i]),
      .q_i   (sq[i]),
      .ctl_o (sc[i+1]),
      .rem_o (srem[i+1]),
      .res_o (sres[i+1]),
      .q_o   (sq[i+1])
    );
  end

  // Prepare numerators q * 2^(F+1) + R and divisor 2R
  tfn_ctl_t              cp_r;
  logic [DEN_W-1:0]      den_r;
  logic [2:0][NUM_W-1:0] num_r;
  logic [ROOT_W-1:0]     root;

  assign root = sres[ROOT_W][ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r <= '0;
    end else begin
      cp_r <= sc[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    den_r <= {root, 1'b0};
    for (int k = 0; k < 3; k++) begin
      num_r[k] <= NUM_W'({sq[ROOT_W][k], {(F + 1){1'b0}}}) + NUM_W'(root);
    end
  end

  // Divide chain, one quotient bit per cell
  tfn_ctl_t              dc   [QW+1];
  logic [DEN_W-1:0]      dden [QW+1];
  logic [2:0][NUM_W-1:0] drem [QW+1];
  logic [2:0][QW-1:0]    dquo [QW+1];

  assign dc[0]   = cp_r;
  assign dden[0] = den_r;
  assign drem[0] = num_r;
  assign dquo[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    tfn_div_cell #(
      .K     (QW - 1 - i),
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QW    (QW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (dc[i]),
      .den_i (dden[i]),
      .rem_i (drem[i]),
      .quo_i (dquo[i]),
      .ctl_o (dc[i+1]),
      .den_o (dden[i+1]),
      .rem_o (drem[i+1]),
      .quo_o (dquo[i+1])
    );
  end

  // Output register: sign applied, zero normal when degenerate
  tfn_ctl_t          cf;
  logic [OW-1:0]     nrm [3];
  logic              out_valid_r;
  logic              out_degen_r;
  logic [OW-1:0]     out_x_r, out_y_r, out_z_r;

  assign cf = dc[QW];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (cf.degen) begin
        nrm[k] = '0;
      end else if (cf.neg[k]) begin
        nrm[k] = OW'(0) - OW'(dquo[QW][k]);
      end else begin
        nrm[k] = OW'(dquo[QW][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cf.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_degen_r <= cf.degen;
    out_x_r     <= nrm[0];
    out_y_r     <= nrm[1];
    out_z_r     <= nrm[2];
  end

  assign out_valid      = out_valid_r;
  assign out_degenerate = out_degen_r;
  assign out_normal_x   = out_x_r;
  assign out_normal_y   = out_y_r;
  assign out_normal_z   = out_z_r;

`ifndef SYNTHESIS
  // Every accepted item comes out after the fixed latency
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("item did not emerge after pipeline latency");

  // Degenerate items carry a zero normal
  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0))
    else $error("degenerate item with nonzero normal");

  // A proper triangle never yields an all-zero normal
  a_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_degenerate) |->
      (out_normal_x != '0 || out_normal_y != '0 || out_normal_z != '0))
    else $error("non-degenerate item with zero normal");
`endif

endmodule

@@ hw/rtl/tfn_sqrt_cell.sv @@
// One bit of a restoring integer square root
module tfn_sqrt_cell import tfn_pkg::*; #(
  parameter int BIT_IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tfn_ctl_t               ctl_i,
  input  logic [SUM_W-1:0]       rem_i,
  input  logic [SUM_W-1:0]       res_i,
  input  logic [2:0][Q_BITS-1:0] q_i,
  output tfn_ctl_t               ctl_o,
  output logic [SUM_W-1:0]       rem_o,
  output logic [SUM_W-1:0]       res_o,
  output logic [2:0][Q_BITS-1:0] q_o
);

  localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * BIT_IDX);

  tfn_ctl_t               ctl_r;
  logic [SUM_W-1:0]       rem_r, rem_nxt;
  logic [SUM_W-1:0]       res_r, res_nxt;
  logic [2:0][Q_BITS-1:0] q_r;
  logic [SUM_W-1:0]       trial;

  // Trial subtract of the current root bit
  always_comb begin
    trial = res_i + BIT;
    if (rem_i >= trial) begin
      rem_nxt = rem_i - trial;
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      rem_nxt = rem_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    q_r   <= q_i;
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign res_o = res_r;
  assign q_o   = q_r;

endmodule

@@ hw/rtl/tfn_div_cell.sv @@
// One quotient bit of a restoring divide, three lanes sharing a divisor
module tfn_div_cell import tfn_pkg::*; #(
  parameter int K     = 0,
  parameter int NUM_W = 46,
  parameter int DEN_W = 32,
  parameter int QW    = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tfn_ctl_t              ctl_i,
  input  logic [DEN_W-1:0]      den_i,
  input  logic [2:0][NUM_W-1:0] rem_i,
  input  logic [2:0][QW-1:0]    quo_i,
  output tfn_ctl_t              ctl_o,
  output logic [DEN_W-1:0]      den_o,
  output logic [2:0][NUM_W-1:0] rem_o,
  output logic [2:0][QW-1:0]    quo_o
);

  tfn_ctl_t              ctl_r;
  logic [DEN_W-1:0]      den_r;
  logic [2:0][NUM_W-1:0] rem_r, rem_nxt;
  logic [2:0][QW-1:0]    quo_r, quo_nxt;
  logic [NUM_W-1:0]      dsh;

  // Divisor aligned to this quotient bit
  always_comb begin
    dsh     = NUM_W'(den_i) << K;
    rem_nxt = rem_i;
    quo_nxt = quo_i;
    for (int l = 0; l < 3; l++) begin
      if (rem_i[l] >= dsh) begin
        rem_nxt[l]    = rem_i[l] - dsh;
        quo_nxt[l][K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_i;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign ctl_o = ctl_r;
  assign den_o = den_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule
